// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros for the route distance minimizer unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

// ===== design/redm_pkg.sv =====
// ---------------------------------------------------------------------------
// redm_pkg
// Commands, codes, table request types and saturating add for the route
// expected distance minimizer.
// ---------------------------------------------------------------------------
package redm_pkg;

    localparam logic [2:0] CMD_PROB   = 3'd0;
    localparam logic [2:0] CMD_DIST   = 3'd1;
    localparam logic [2:0] CMD_CAB    = 3'd2;
    localparam logic [2:0] CMD_NODE   = 3'd3;
    localparam logic [2:0] CMD_FINISH = 3'd4;

    localparam logic CFG_PENALTY   = 1'b0;
    localparam logic CFG_INIT_BEST = 1'b1;

    localparam logic KIND_ROUTE = 1'b0;
    localparam logic KIND_BEST  = 1'b1;

    localparam logic [16:0] ONE_Q16         = 17'h10000;
    localparam logic [31:0] PENALTY_RESET   = 32'd6553600;
    localparam logic [31:0] INIT_BEST_RESET = 32'd655360000;

    typedef struct packed {
        logic        wr_prob;
        logic        wr_cab;
        logic        wr_dist;
        logic        rd;
        logic        at_start;
        logic [4:0]  node;
        logic [4:0]  row;
        logic [31:0] value;
    } tbl_req_t;

    typedef struct packed {
        logic [31:0] leg;
        logic [15:0] prob;
    } tbl_rsp_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== design/redm_tables.sv =====
// ---------------------------------------------------------------------------
// redm_tables
// Cluster tables: pickup probability and cab distance per cluster, and the
// cluster to cluster distance table. Synchronous read; the leg distance and
// probability come out registered and range checked.
// ---------------------------------------------------------------------------
module redm_tables import redm_pkg::*; #(
    parameter int CLUSTERS = 32
) (
    input  logic     clk,
    input  tbl_req_t req,
    output tbl_rsp_t rsp
);

    localparam int IDX_W   = $clog2(CLUSTERS);
    localparam int DIST_N  = CLUSTERS * CLUSTERS;
    localparam int DIST_AW = $clog2(DIST_N);

    logic [47:0] info_mem [CLUSTERS];
    logic [31:0] dist_mem [DIST_N];

    logic [8:0]         node_w;
    logic [8:0]         row_w;
    logic               node_ok;
    logic               row_ok;
    logic [IDX_W-1:0]   node_idx;
    logic [IDX_W-1:0]   row_idx;
    logic [DIST_AW-1:0] dist_addr;

    logic [47:0] info_rd_reg;
    logic [31:0] dist_rd_reg;
    logic        node_ok_reg;
    logic        row_ok_reg;
    logic        start_reg;

    assign node_w    = 9'(req.node);
    assign row_w     = 9'(req.row);
    assign node_ok   = node_w < 9'(CLUSTERS);
    assign row_ok    = row_w < 9'(CLUSTERS);
    assign node_idx  = node_w[IDX_W-1:0];
    assign row_idx   = row_w[IDX_W-1:0];
    assign dist_addr = DIST_AW'(row_idx) * DIST_AW'(CLUSTERS) + DIST_AW'(node_idx);

    always_ff @(posedge clk)
    begin
        if (req.wr_prob && node_ok)
        begin
            info_mem[node_idx][15:0] <= req.value[15:0];
        end
        if (req.wr_cab && node_ok)
        begin
            info_mem[node_idx][47:16] <= req.value;
        end
        if (req.rd)
        begin
            info_rd_reg <= info_mem[node_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_dist && node_ok && row_ok)
        begin
            dist_mem[dist_addr] <= req.value;
        end
        if (req.rd)
        begin
            dist_rd_reg <= dist_mem[dist_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            node_ok_reg <= node_ok;
            row_ok_reg  <= row_ok;
            start_reg   <= req.at_start;
        end
    end

    always_comb
    begin
        rsp.prob = node_ok_reg ? info_rd_reg[15:0] : 16'd0;
        if (start_reg)
        begin
            rsp.leg = node_ok_reg ? info_rd_reg[47:16] : 32'd0;
        end
        else
        begin
            rsp.leg = (node_ok_reg && row_ok_reg) ? dist_rd_reg : 32'd0;
        end
    end

endmodule

// ===== design/route_expected_distance_minimizer_unit.sv =====
// ---------------------------------------------------------------------------
// route_expected_distance_minimizer_unit
// Route node items: the table read at accept, then ST_READ (leg add),
// ST_MUL (distance times survival) and ST_ACC (cost accumulate); a last
// node then moves to ST_REPORT, where its result enters the output register.
// Finish goes to ST_REPORT; table writes and unknown commands stay in ST_IDLE.
// A report waits while the previous result is held by result_stall.
// Reset (rst_n low, async) clears the search state and loads register
// defaults; table contents stay undefined until written, no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module route_expected_distance_minimizer_unit import redm_pkg::*; #(
    parameter int CLUSTERS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  command,
    input  logic [4:0]  node,
    input  logic [4:0]  from_node,
    input  logic [31:0] value,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [31:0] cost,
    output logic        new_best,
    output logic [15:0] route_number,
    output logic        found
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_ACC    = 5'b01000,
        ST_REPORT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] penalty_reg;
    logic [31:0] init_best_reg;

    logic [31:0] running_reg;
    logic [16:0] surv_reg;
    logic [31:0] cost_reg;
    logic [4:0]  prev_reg;
    logic        start_reg;
    logic [15:0] count_reg;
    logic [31:0] best_cost_reg;
    logic [15:0] best_route_reg;
    logic        found_reg;

    logic [4:0]  node_reg;
    logic        last_reg;
    logic        fin_reg;
    logic [15:0] p_reg;
    logic [31:0] t1_reg;
    logic [31:0] pen_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [31:0] cost_out_reg;
    logic        new_best_reg;
    logic [15:0] route_out_reg;
    logic        found_out_reg;

    logic        accept;
    logic        report_load;
    tbl_req_t    req;
    tbl_rsp_t    rsp;
    logic [48:0] mul_run;
    logic [33:0] mul_surv;
    logic [47:0] mul_cost;
    logic [48:0] mul_pen;
    logic [31:0] final_cost;
    logic        better;

    assign item_stall  = state_reg != ST_IDLE;
    assign accept      = item_valid && !item_stall;
    assign report_load = (state_reg == ST_REPORT) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        req.wr_prob  = accept && (command == CMD_PROB);
        req.wr_cab   = accept && (command == CMD_CAB);
        req.wr_dist  = accept && (command == CMD_DIST);
        req.rd       = accept && (command == CMD_NODE);
        req.at_start = start_reg;
        req.node     = node;
        req.row      = (command == CMD_DIST) ? from_node : prev_reg;
        req.value    = value;
    end

    redm_tables #(
        .CLUSTERS (CLUSTERS)
    ) u_tables (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    assign mul_run    = 49'(running_reg) * 49'(surv_reg);
    assign mul_surv   = 34'(surv_reg) * 34'(ONE_Q16 - {1'b0, p_reg});
    assign mul_cost   = 48'(t1_reg) * 48'(p_reg);
    assign mul_pen    = 49'(penalty_reg) * 49'(surv_reg);
    assign final_cost = sat_add(cost_reg, pen_reg);
    assign better     = final_cost < best_cost_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_NODE))
                begin
                    state_next = ST_READ;
                end
                else if (accept && (command == CMD_FINISH))
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_READ:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = last_reg ? ST_REPORT : ST_IDLE;
            ST_REPORT:
            begin
                if (report_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            penalty_reg    <= PENALTY_RESET;
            init_best_reg  <= INIT_BEST_RESET;
            running_reg    <= 32'd0;
            surv_reg       <= ONE_Q16;
            cost_reg       <= 32'd0;
            prev_reg       <= 5'd0;
            start_reg      <= 1'b1;
            count_reg      <= 16'd0;
            best_cost_reg  <= INIT_BEST_RESET;
            best_route_reg <= 16'd0;
            found_reg      <= 1'b0;
            last_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_PENALTY:   penalty_reg   <= cfg_data;
                    CFG_INIT_BEST: init_best_reg <= cfg_data;
                    default:       penalty_reg   <= penalty_reg;
                endcase
            end
            if (accept)
            begin
                last_reg <= last;
                fin_reg  <= command == CMD_FINISH;
            end
            if (report_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_valid && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_READ:
                begin
                    running_reg <= sat_add(running_reg, rsp.leg);
                    prev_reg    <= node_reg;
                    start_reg   <= 1'b0;
                end
                ST_MUL:
                begin
                    surv_reg <= mul_surv[32:16];
                end
                ST_ACC:
                begin
                    cost_reg <= sat_add(cost_reg, mul_cost[47:16]);
                end
                ST_REPORT:
                begin
                    if (report_load)
                    begin
                        running_reg   <= 32'd0;
                        surv_reg      <= ONE_Q16;
                        cost_reg      <= 32'd0;
                        prev_reg      <= 5'd0;
                        start_reg     <= 1'b1;
                        if (fin_reg)
                        begin
                            count_reg      <= 16'd0;
                            best_cost_reg  <= init_best_reg;
                            best_route_reg <= 16'd0;
                            found_reg      <= 1'b0;
                        end
                        else
                        begin
                            count_reg <= count_reg + 16'd1;
                            if (better)
                            begin
                                best_cost_reg  <= final_cost;
                                best_route_reg <= count_reg;
                                found_reg      <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    start_reg <= start_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg <= node;
        end
        if (state_reg == ST_READ)
        begin
            p_reg <= rsp.prob;
        end
        if (state_reg == ST_MUL)
        begin
            t1_reg <= mul_run[47:16];
        end
        if (state_reg == ST_ACC)
        begin
            pen_reg <= mul_pen[47:16];
        end
        if (report_load)
        begin
            if (fin_reg)
            begin
                kind_reg      <= KIND_BEST;
                cost_out_reg  <= best_cost_reg;
                new_best_reg  <= 1'b0;
                route_out_reg <= best_route_reg;
                found_out_reg <= found_reg;
            end
            else
            begin
                kind_reg      <= KIND_ROUTE;
                cost_out_reg  <= final_cost;
                new_best_reg  <= better;
                route_out_reg <= count_reg;
                found_out_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign cost         = cost_out_reg;
    assign new_best     = new_best_reg;
    assign route_number = route_out_reg;
    assign found        = found_out_reg;

    `ASSERT_CLK(a_surv_max, clk, rst_n, surv_reg <= ONE_Q16)
    `ASSERT_CLK(a_report_hold, clk, rst_n, (state_reg == ST_REPORT && out_valid_reg && result_stall) |=> (state_reg == ST_REPORT))
    `ASSERT_CLK(a_best_update, clk, rst_n, (report_load && !fin_reg && better) |=> (best_cost_reg == cost_out_reg && found_reg))
    `ASSERT_CLK(a_finish_clear, clk, rst_n, (report_load && fin_reg) |=> (count_reg == 16'd0 && !found_reg && start_reg))
    `ASSERT_NEVER(a_route_found, clk, rst_n, result_valid && kind == KIND_ROUTE && found)

endmodule

// ===== test/tb_route_expected_distance_minimizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_route_expected_distance_minimizer_unit
// Self-checking bench for the route expected distance minimizer. It loads the
// probability, cluster distance and cab distance tables and then sends routes.
// A local fixed-point copy of the cost rules predicts every route cost report
// and best-of-query report. Each report is checked field by field in order.
// Random gaps on the item side and random stalls on the report side run
// alongside. The routes cover register extremes, ties and dropped routes.
// ----------------------------------------------------------------------------
module tb_route_expected_distance_minimizer_unit import redm_pkg::*; ();

    localparam logic [2:0] CMD_MAX           = 3'd7;
    localparam int         CYCLE_LIMIT       = 3000000;
    localparam int         SETTLE_CYCLES     = 10;

    typedef struct packed {
        logic        kind;
        logic [31:0] cost;
        logic        new_best;
        logic [15:0] route_number;
        logic        found;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_PENALTY;
    logic [31:0] cfg_data = 32'd0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [2:0]  command = CMD_PROB;
    logic [4:0]  node = 5'd0;
    logic [4:0]  from_node = 5'd0;
    logic [31:0] value = 32'd0;
    logic        last = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        kind;
    logic [31:0] cost;
    logic        new_best;
    logic [15:0] route_number;
    logic        found;

    // local copy of the block state
    logic [15:0] prob_tbl [32];
    logic [31:0] dist_tbl [1024];
    logic [31:0] cab_tbl [32];
    bit          prob_set [32];
    bit          dist_set [1024];
    bit          cab_set [32];
    logic [31:0] penalty_reg = PENALTY_RESET;
    logic [31:0] init_best_reg = INIT_BEST_RESET;
    logic [31:0] run_dist = 32'd0;
    logic [16:0] survival = ONE_Q16;
    logic [31:0] route_cost = 32'd0;
    logic [4:0]  prev_node = 5'd0;
    bit          at_start = 1'b1;
    logic [15:0] route_count = 16'd0;
    logic [31:0] best_cost = INIT_BEST_RESET;
    logic [15:0] best_route = 16'd0;
    bit          best_found = 1'b0;

    report_t     pending_reports [$];
    report_t     want;
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          sender_idles = 1'b0;
    bit          receiver_stalls = 1'b0;
    int          stall_hold = 0;
    bit          stall_next;

    route_expected_distance_minimizer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .node         (node),
        .from_node    (from_node),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .cost         (cost),
        .new_best     (new_best),
        .route_number (route_number),
        .found        (found)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = {32'd0, a} + b;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 2);
        if (r < 9)
            return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [31:0] rand_prob();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: r[15:0] = 16'h0000;
            1: r[15:0] = 16'hFFFF;
            2, 3: r[15:0] = 16'($urandom_range(0, 16'h2000));
            4, 5: r[15:0] = 16'($urandom_range(16'hC000, 16'hFFFF));
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_distance();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return $urandom;
            default: return $urandom_range(0, 32'd200 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_register_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'd5000 << 16);
        endcase
    endfunction

    function automatic void clear_route();
        run_dist = 32'd0;
        survival = ONE_Q16;
        route_cost = 32'd0;
        prev_node = 5'd0;
        at_start = 1'b1;
    endfunction

    function automatic void clear_search();
        clear_route();
        route_count = 16'd0;
        best_cost = init_best_reg;
        best_route = 16'd0;
        best_found = 1'b0;
    endfunction

    function automatic void queue_report(input report_t rep);
        pending_reports = {pending_reports, rep};
    endfunction

    task automatic update_route_costs(input logic [2:0] cmd, input logic [4:0] n,
                                      input logic [4:0] src, input logic [31:0] val,
                                      input logic lst);
        logic [15:0] p;
        logic [31:0] leg;
        logic [63:0] t;
        report_t     rep;
        case (cmd)
            CMD_PROB:
            begin
                prob_tbl[n] = val[15:0];
                prob_set[n] = 1'b1;
            end
            CMD_DIST:
            begin
                dist_tbl[{src, n}] = val;
                dist_set[{src, n}] = 1'b1;
            end
            CMD_CAB:
            begin
                cab_tbl[n] = val;
                cab_set[n] = 1'b1;
            end
            CMD_NODE:
            begin
                p = prob_tbl[n];
                leg = at_start ? cab_tbl[n] : dist_tbl[{prev_node, n}];
                run_dist = add_sat(run_dist, {32'd0, leg});
                t = ({32'd0, run_dist} * {47'd0, survival}) >> 16;
                t = (t * {48'd0, p}) >> 16;
                route_cost = add_sat(route_cost, t);
                t = ({47'd0, survival} * ({47'd0, ONE_Q16} - {48'd0, p})) >> 16;
                survival = t[16:0];
                prev_node = n;
                at_start = 1'b0;
                if (lst)
                begin
                    route_cost = add_sat(route_cost,
                                         ({32'd0, penalty_reg} * {47'd0, survival}) >> 16);
                    rep.kind = KIND_ROUTE;
                    rep.cost = route_cost;
                    rep.new_best = route_cost < best_cost;
                    rep.route_number = route_count;
                    rep.found = 1'b0;
                    if (rep.new_best)
                    begin
                        best_cost = route_cost;
                        best_route = route_count;
                        best_found = 1'b1;
                    end
                    queue_report(rep);
                    route_count = route_count + 16'd1;
                    clear_route();
                end
            end
            CMD_FINISH:
            begin
                rep.kind = KIND_BEST;
                rep.cost = best_cost;
                rep.new_best = 1'b0;
                rep.route_number = best_route;
                rep.found = best_found;
                queue_report(rep);
                clear_search();
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_reports.size() == 0)
                note_mismatch("report with none pending (cost)", 32'd0, cost);
            else
            begin
                want = pending_reports.pop_front();
                if (kind !== want.kind)
                    note_mismatch("kind", want.kind, kind);
                if (cost !== want.cost)
                    note_mismatch("cost", want.cost, cost);
                if (new_best !== want.new_best)
                    note_mismatch("new_best", want.new_best, new_best);
                if (route_number !== want.route_number)
                    note_mismatch("route_number", want.route_number, route_number);
                if (found !== want.found)
                    note_mismatch("found", want.found, found);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!receiver_stalls)
            result_stall <= 1'b0;
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            stall_next = ($urandom_range(0, 2) == 0);
            result_stall <= stall_next;
            stall_hold <= stall_next ? idle_length() : $urandom_range(0, 6);
        end
    end

    task automatic send_item(input logic [2:0] cmd, input logic [4:0] n,
                             input logic [4:0] src, input logic [31:0] val,
                             input logic lst);
        int gap;
        item_valid <= 1'b1;
        command <= cmd;
        node <= n;
        from_node <= src;
        value <= val;
        last <= lst;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        update_route_costs(cmd, n, src, val, lst);
        if (cmd <= CMD_FINISH)
            items_sent++;
        gap = (sender_idles && $urandom_range(0, 1) == 0) ? idle_length() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every pending report is back and the block is quiet
    task automatic await_reports();
        item_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        await_reports();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_PENALTY)
            penalty_reg = data;
        else
            init_best_reg = data;
    endtask

    // load any unset table entry this node would read before sending it
    task automatic send_node(input logic [4:0] n, input logic lst);
        if (!prob_set[n])
            send_item(CMD_PROB, n, 5'($urandom), rand_prob(), 1'($urandom));
        if (at_start && !cab_set[n])
            send_item(CMD_CAB, n, 5'($urandom), rand_distance(), 1'($urandom));
        if (!at_start && !dist_set[{prev_node, n}])
            send_item(CMD_DIST, n, prev_node, rand_distance(), 1'($urandom));
        send_item(CMD_NODE, n, 5'($urandom), $urandom, lst);
    endtask

    task automatic send_route(input int len, input bit closed);
        for (int i = 0; i < len; i++)
            send_node(5'($urandom), closed && i == len - 1);
    endtask

    task automatic send_finish();
        send_item(CMD_FINISH, 5'($urandom), 5'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic test_directed_routes();
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        send_item(CMD_PROB, 5'd0, 5'd31, 32'hFFFF_0000, 1'b1);
        send_item(CMD_PROB, 5'd31, 5'd0, 32'h0000_FFFF, 1'b0);
        send_item(CMD_PROB, 5'd5, 5'd0, 32'h0000_8000, 1'b0);
        send_item(CMD_CAB, 5'd0, 5'd0, 32'd0, 1'b0);
        send_item(CMD_CAB, 5'd31, 5'd31, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_CAB, 5'd5, 5'd0, 32'h000A_0000, 1'b0);
        send_item(CMD_DIST, 5'd5, 5'd0, 32'h0003_0000, 1'b0);
        send_item(CMD_DIST, 5'd31, 5'd5, 32'h0007_8000, 1'b0);
        send_item(CMD_DIST, 5'd0, 5'd31, 32'hFFFF_FFFF, 1'b1);
        send_node(5'd5, 1'b1);
        send_node(5'd0, 1'b0);
        send_node(5'd5, 1'b0);
        send_node(5'd31, 1'b1);
        send_node(5'd31, 1'b0);
        send_node(5'd0, 1'b1);
        send_node(5'd31, 1'b1);
        send_item(CMD_FINISH, 5'd31, 5'd31, 32'hFFFF_FFFF, 1'b1);
        await_reports();
    endtask

    task automatic test_special_cases();
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        // equal cost to the best is not a new best
        send_node(5'd5, 1'b1);
        send_node(5'd5, 1'b1);
        for (int c = CMD_FINISH + 1; c <= CMD_MAX; c++)
            send_item(3'(c), 5'($urandom), 5'($urandom), $urandom, 1'b1);
        send_node(5'd0, 1'b0);
        send_item(CMD_MAX, 5'd5, 5'd0, 32'hFFFF_FFFF, 1'b1);
        send_node(5'd5, 1'b1);
        // drop a route in progress
        send_node(5'd5, 1'b0);
        send_finish();
        send_node(5'd5, 1'b1);
        send_finish();
        // new starting best applies only from the next finish
        write_register(CFG_INIT_BEST, 32'h0001_0000);
        send_node(5'd5, 1'b1);
        send_finish();
        send_node(5'd5, 1'b1);
        send_finish();
        await_reports();
    endtask

    task automatic test_register_settings();
        logic [31:0] pen_set [6];
        logic [31:0] best_set [6];
        pen_set = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, $urandom, PENALTY_RESET};
        best_set = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, $urandom, INIT_BEST_RESET};
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            write_register(CFG_PENALTY, pen_set[k]);
            write_register(CFG_INIT_BEST, best_set[k]);
            send_finish();
            repeat (3) send_route($urandom_range(1, 3), 1'b1);
            send_node(5'd31, 1'b1);
            send_finish();
        end
        await_reports();
    endtask

    task automatic test_random_routes();
        int stop_at;
        int phase_end;
        int pause_at;
        int pick;
        stop_at = items_sent + 1050;
        while (items_sent < stop_at)
        begin
            phase_end = items_sent + $urandom_range(150, 300);
            pick = $urandom_range(0, 3);
            sender_idles = pick[0];
            receiver_stalls = pick[1];
            if ($urandom_range(0, 2) == 0)
            begin
                write_register(CFG_PENALTY, rand_register_value());
                write_register(CFG_INIT_BEST, rand_register_value());
            end
            pause_at = items_sent + $urandom_range(20, 100);
            while (items_sent < phase_end && items_sent < stop_at)
            begin
                if (items_sent >= pause_at)
                begin
                    await_reports();
                    pause_at = phase_end;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_route($urandom_range(1, 6), 1'b1);
                else if (pick < 76)
                begin
                    send_route($urandom_range(1, 4), 1'b0);
                    send_finish();
                end
                else if (pick < 80)
                    send_item(CMD_PROB, 5'($urandom), 5'($urandom), rand_prob(),
                              1'($urandom));
                else if (pick < 84)
                    send_item(CMD_DIST, 5'($urandom), 5'($urandom), rand_distance(),
                              1'($urandom));
                else if (pick < 88)
                    send_item(CMD_CAB, 5'($urandom), 5'($urandom), rand_distance(),
                              1'($urandom));
                else if (pick < 94)
                    send_finish();
                else
                    send_item(3'($urandom_range(CMD_FINISH + 1, CMD_MAX)), 5'($urandom),
                              5'($urandom), $urandom, 1'($urandom));
            end
        end
        await_reports();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_routes();
        test_special_cases();
        test_register_settings();
        test_random_routes();
        await_reports();
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/redm_pkg.sv
design/redm_tables.sv
design/route_expected_distance_minimizer_unit.sv
test/tb_route_expected_distance_minimizer_unit.sv
